// ===== design/swld_pkg.sv =====
// Shared types and constants for the sync-word length deframer.
// Used by swld_fsm and sync_word_length_deframer; depends on nothing.
`default_nettype none

package swld_pkg;

  localparam logic [7:0]  SYNC_FIRST       = 8'h94;
  localparam logic [7:0]  SYNC_SECOND      = 8'hC3;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd512;

  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_REJECTED = 2'd2;

  typedef enum logic [4:0] {
    PH_HUNT1   = 5'b00001,
    PH_HUNT2   = 5'b00010,
    PH_LEN_HI  = 5'b00100,
    PH_LEN_LO  = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  length_high;
    logic [15:0] length_total;
    logic [15:0] bytes_left;
  } deframe_state_t;

  typedef struct packed {
    logic        emit;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] length;
  } deframe_result_t;

endpackage

`default_nettype wire

// ===== design/sync_word_length_deframer.sv =====
// Top level of the sync-word length-prefixed frame deframer.
// Depends on swld_pkg and swld_fsm.
//
//   channel   | signals                          | payload
//   s_axis    | tvalid tready tdata[7:0]         | received byte
//   m_axis    | tvalid tready tdata tuser tlast  | kind, byte, length, last
//   cfg       | valid ready data[15:0]           | max_length
//
// One byte is taken per cycle while s_axis_tready is high; its result is then registered.
// The input register and the result register each hold one item, and the
// header/payload state advances once per byte in a single pass.
// rst clears the state to hunting and max_length to 512.
// A stalled m_axis holds the result; input stalls only when a held byte
// would produce a result while the result register stays full.
`default_nettype none

module sync_word_length_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] frame_length
  output      logic [1:0]  m_axis_tuser,   // [1:0] out_kind
  output      logic        m_axis_tlast,   // out_last
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data
);
  import swld_pkg::*;

  logic            in_valid;
  logic [7:0]      in_byte;
  logic [15:0]     max_length;
  deframe_state_t  st;
  deframe_state_t  st_next;
  deframe_result_t res;
  logic            advance;

  swld_fsm u_fsm (
    .cur        (st),
    .in_byte    (in_byte),
    .max_length (max_length),
    .nxt        (st_next),
    .res        (res)
  );

  assign advance       = in_valid && (!res.emit || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      max_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase        <= PH_HUNT1;
      st.length_high  <= 8'd0;
      st.length_total <= 16'd0;
      st.bytes_left   <= 16'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && res.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      m_axis_tdata <= {res.length, res.data};
      m_axis_tuser <= res.kind;
      m_axis_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire

// ===== design/swld_fsm.sv =====
// Per-byte next-state and result logic of the deframer.
// Depends on swld_pkg.
`default_nettype none

module swld_fsm (
  input  wire swld_pkg::deframe_state_t  cur,
  input  wire logic [7:0]                in_byte,
  input  wire logic [15:0]               max_length,
  output swld_pkg::deframe_state_t       nxt,
  output swld_pkg::deframe_result_t      res
);
  import swld_pkg::*;

  logic [15:0] len_word;

  assign len_word = {cur.length_high, in_byte};

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_HUNT2: begin
        if (in_byte == SYNC_SECOND) begin
          nxt.phase = PH_LEN_HI;
        end else if (in_byte == SYNC_FIRST) begin
          nxt.phase = PH_HUNT2;
        end else begin
          nxt.phase = PH_HUNT1;
        end
      end
      PH_LEN_HI: begin
        nxt.length_high = in_byte;
        nxt.phase       = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        nxt.length_total = len_word;
        if (len_word > max_length) begin
          res.emit   = 1'b1;
          res.kind   = KIND_REJECTED;
          res.length = len_word;
          if (cur.length_high == SYNC_FIRST && in_byte == SYNC_SECOND) begin
            nxt.phase = PH_LEN_HI;
          end else if (in_byte == SYNC_FIRST) begin
            nxt.phase = PH_HUNT2;
          end else begin
            nxt.phase = PH_HUNT1;
          end
        end else if (len_word == 16'd0) begin
          nxt.bytes_left = 16'd0;
          nxt.phase      = PH_HUNT1;
          res.emit       = 1'b1;
          res.kind       = KIND_EMPTY;
          res.last       = 1'b1;
        end else begin
          nxt.bytes_left = len_word;
          nxt.phase      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.emit   = 1'b1;
        res.kind   = KIND_PAYLOAD;
        res.data   = in_byte;
        res.length = cur.length_total;
        res.last   = (cur.bytes_left <= 16'd1);
        if (cur.bytes_left <= 16'd1) begin
          nxt.bytes_left = 16'd0;
          nxt.phase      = PH_HUNT1;
        end else begin
          nxt.bytes_left = cur.bytes_left - 16'd1;
        end
      end
      default: begin
        nxt.phase = (in_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase
  end

endmodule

`default_nettype wire
